// ===== rtl/modexp_pkg.sv =====
// Shared types for the modular exponentiation block: controller/datapath command and status.
package modexp_pkg;

  // Width of every field port on the block boundary.
  localparam int unsigned FIELD_W = 32;

  // Reset value of the modulus register.
  localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd23;

  // Operand pairing handed to the modular multiplier.
  typedef enum logic [1:0] {
    MUL_REDUCE = 2'd0,  // base * 1, reduces the base
    MUL_ACC    = 2'd1,  // acc * sq
    MUL_SQUARE = 2'd2   // sq * sq
  } mul_sel_e;

  // Source of the delivered result.
  typedef enum logic [1:0] {
    RES_ONE  = 2'd0,
    RES_ZERO = 2'd1,
    RES_ACC  = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic     load;       // capture base, exponent; preset acc
    logic     mul_start;  // launch one modular multiply
    mul_sel_e mul_sel;
    logic     acc_we;     // write multiplier result to acc
    logic     sq_we;      // write multiplier result to sq
    logic     exp_shift;  // drop the exponent LSB
    logic     res_valid;  // emit a result item
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;       // whole exponent register is zero
    logic exp_lsb;        // current exponent bit
    logic exp_rest_zero;  // no set bit above the current one
    logic mod_zero;
    logic mul_done;
  } sts_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: base^exponent mod modulus.
//
//  channel   ports                                        direction  handshake
//  ------    -----------------------------------------    ---------  -------------------------
//  item in   start_i, base_value_i, exponent_value_i      in         start_i && !busy_o
//  result    done_o, power_result_o                       out        done_o strobe, one cycle
//  config    cfg_we_i, cfg_wdata_i (modulus)              in         cfg_we_i, no wait
//
// The shared multiplier, one operand bit a cycle, sets the pace: one multiply reduces the
// base, then each exponent bit up to the highest set one costs a multiply when set and a
// square when below the highest. A zero exponent or modulus skips the multiplier: the
// check state emits the result without any multiply.
// Reset idles the controller and loads modulus 23; the receiver never stalls the strobe.
module modular_exponentiation #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item in
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [modexp_pkg::FIELD_W-1:0]     base_value_i,
  input  logic [modexp_pkg::FIELD_W-1:0]     exponent_value_i,
  // result out
  output logic                               done_o,
  output logic [modexp_pkg::FIELD_W-1:0]     power_result_o,
  // modulus register
  input  logic                               cfg_we_i,
  input  logic [modexp_pkg::FIELD_W-1:0]     cfg_wdata_i
);

  modexp_pkg::cmd_t cmd;
  modexp_pkg::sts_t sts;
  logic [WIDTH-1:0] res;

  // Controller: issues commands, never touches operand data.
  modexp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // Datapath: operands are trimmed to WIDTH bits here; upper bits are ignored.
  modexp_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i[WIDTH-1:0]),
    .base_i     (base_value_i[WIDTH-1:0]),
    .exp_i      (exponent_value_i[WIDTH-1:0]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(done_o),
    .res_o      (res)
  );

  // Zero-extend the result to the port width.
  assign power_result_o = modexp_pkg::FIELD_W'(res);

  // An accepted item always makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  // The result strobe shows up only once the block is idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // Strobes are single-cycle: a second item cannot finish right behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

endmodule

// ===== rtl/modexp_modmul.sv =====
// Iterative modular multiplier: one multiplier bit per cycle, interleaved reduction.
module modexp_modmul #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] r_o
);

  localparam int unsigned TW    = WIDTH + 2;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] a_q, a_d, b_q, m_q, r_q, r_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d, done_q, done_d;
  logic [TW-1:0]    t, m1, m2;

  // t = 2r + (a_msb ? b : 0) stays below 3m because r < m and b <= m.
  always_comb begin
    t  = {1'b0, r_q, 1'b0} + (a_q[WIDTH-1] ? TW'(b_q) : '0);
    m1 = TW'(m_q);
    m2 = {1'b0, m_q, 1'b0};
    priority if (t >= m2) begin
      r_d = WIDTH'(t - m2);
    end else if (t >= m1) begin
      r_d = WIDTH'(t - m1);
    end else begin
      r_d = WIDTH'(t);
    end
  end

  always_comb begin
    a_d    = a_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d   = a_i;
      cnt_d = CNT_W'(WIDTH - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      a_d   = {a_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    if (start_i) begin
      b_q <= b_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (run_q) begin
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

// ===== rtl/modexp_dp.sv =====
// Datapath: modulus register, operand registers, shared multiplier and result register.
module modexp_dp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [WIDTH-1:0]      cfg_wdata_i,
  input  logic [WIDTH-1:0]      base_i,
  input  logic [WIDTH-1:0]      exp_i,
  input  modexp_pkg::cmd_t      cmd_i,
  output modexp_pkg::sts_t      sts_o,
  output logic                  res_valid_o,
  output logic [WIDTH-1:0]      res_o
);

  logic [WIDTH-1:0] mod_q, base_q, exp_q, acc_q, sq_q, res_q;
  logic             res_valid_q;
  logic [WIDTH-1:0] mul_a, mul_b, mul_r;
  logic             mul_done;

  always_comb begin
    unique case (cmd_i.mul_sel)
      modexp_pkg::MUL_REDUCE: begin
        mul_a = base_q;
        mul_b = WIDTH'(1);
      end
      modexp_pkg::MUL_ACC: begin
        mul_a = acc_q;
        mul_b = sq_q;
      end
      modexp_pkg::MUL_SQUARE: begin
        mul_a = sq_q;
        mul_b = sq_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  modexp_modmul #(
    .WIDTH(WIDTH)
  ) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .m_i    (mod_q),
    .done_o (mul_done),
    .r_o    (mul_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= modexp_pkg::MODULUS_RESET[WIDTH-1:0];
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
      res_valid_q <= cmd_i.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i;
      exp_q  <= exp_i;
      acc_q  <= WIDTH'(1);
    end else begin
      if (cmd_i.exp_shift) begin
        exp_q <= {1'b0, exp_q[WIDTH-1:1]};
      end
      if (cmd_i.acc_we) begin
        acc_q <= mul_r;
      end
    end
    if (cmd_i.sq_we) begin
      sq_q <= mul_r;
    end
    if (cmd_i.res_valid) begin
      unique case (cmd_i.res_sel)
        modexp_pkg::RES_ONE:  res_q <= WIDTH'(1);
        modexp_pkg::RES_ZERO: res_q <= '0;
        modexp_pkg::RES_ACC:  res_q <= acc_q;
        default:              res_q <= '0;
      endcase
    end
  end

  assign sts_o.exp_zero      = (exp_q == '0);
  assign sts_o.exp_lsb       = exp_q[0];
  assign sts_o.exp_rest_zero = (exp_q[WIDTH-1:1] == '0);
  assign sts_o.mod_zero      = (mod_q == '0);
  assign sts_o.mul_done      = mul_done;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/modexp_ctrl.sv =====
// Controller: sequences base reduction and square-and-multiply over the exponent bits.
module modexp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  modexp_pkg::sts_t sts_i,
  output modexp_pkg::cmd_t cmd_o,
  output logic             busy_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CHECK    = 3'd1;
  localparam logic [2:0] ST_WAIT_RED = 3'd2;
  localparam logic [2:0] ST_BIT      = 3'd3;
  localparam logic [2:0] ST_WAIT_ACC = 3'd4;
  localparam logic [2:0] ST_SQ       = 3'd5;
  localparam logic [2:0] ST_WAIT_SQ  = 3'd6;

  logic [2:0]           state_q, state_d;
  modexp_pkg::mul_sel_e sel_q, sel_d;

  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    cmd_o         = '0;
    cmd_o.mul_sel = sel_q;
    cmd_o.res_sel = modexp_pkg::RES_ACC;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts_i.exp_zero) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_sel   = modexp_pkg::RES_ONE;
          state_d         = ST_IDLE;
        end else if (sts_i.mod_zero) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_sel   = modexp_pkg::RES_ZERO;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = modexp_pkg::MUL_REDUCE;
          sel_d           = modexp_pkg::MUL_REDUCE;
          state_d         = ST_WAIT_RED;
        end
      end
      ST_WAIT_RED: begin
        if (sts_i.mul_done) begin
          cmd_o.sq_we = 1'b1;
          state_d     = ST_BIT;
        end
      end
      ST_BIT: begin
        if (sts_i.exp_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = modexp_pkg::MUL_ACC;
          sel_d           = modexp_pkg::MUL_ACC;
          state_d         = ST_WAIT_ACC;
        end else begin
          state_d = ST_SQ;
        end
      end
      ST_WAIT_ACC: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_we = 1'b1;
          state_d      = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.exp_shift = 1'b1;
        if (sts_i.exp_rest_zero) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_sel   = modexp_pkg::RES_ACC;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = modexp_pkg::MUL_SQUARE;
          sel_d           = modexp_pkg::MUL_SQUARE;
          state_d         = ST_WAIT_SQ;
        end
      end
      ST_WAIT_SQ: begin
        if (sts_i.mul_done) begin
          cmd_o.sq_we = 1'b1;
          state_d     = ST_BIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= modexp_pkg::MUL_REDUCE;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // A multiply finishes only while the controller waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == ST_WAIT_RED || state_q == ST_WAIT_ACC ||
                        state_q == ST_WAIT_SQ))
    else $error("multiplier done outside a wait state");

  // Every emitted result returns the controller to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_valid |=> (state_q == ST_IDLE))
    else $error("result emitted without returning to idle");

endmodule
